FILE: src/gfc_pkg.sv
`default_nettype none

package gfc_pkg;

  // Frame layout: eight covered bytes, then the received CRC byte.
  localparam int FRAME_LEN    = 9;
  localparam int STORED_BYTES = 7;
  localparam int POS_W        = 4;
  localparam int IDX_W        = $clog2(STORED_BYTES);

  // Position of the CRC byte within the frame.
  localparam logic [POS_W-1:0] CRC_POS = POS_W'(FRAME_LEN - 1);
  localparam logic [POS_W-1:0] LAST_STORED_POS = POS_W'(STORED_BYTES);

  // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // Hat switch codes, clockwise from up; anything else is centre.
  localparam logic [7:0] HAT_UP         = 8'd0;
  localparam logic [7:0] HAT_UP_RIGHT   = 8'd1;
  localparam logic [7:0] HAT_RIGHT      = 8'd2;
  localparam logic [7:0] HAT_DOWN_RIGHT = 8'd3;
  localparam logic [7:0] HAT_DOWN       = 8'd4;
  localparam logic [7:0] HAT_DOWN_LEFT  = 8'd5;
  localparam logic [7:0] HAT_LEFT       = 8'd6;
  localparam logic [7:0] HAT_UP_LEFT    = 8'd7;

  // Pressed-direction bits.
  localparam logic [3:0] DIR_UP    = 4'b0001;
  localparam logic [3:0] DIR_DOWN  = 4'b0010;
  localparam logic [3:0] DIR_LEFT  = 4'b0100;
  localparam logic [3:0] DIR_RIGHT = 4'b1000;
  localparam logic [3:0] DIR_NONE  = 4'b0000;

  typedef logic [7:0] byte_t;

  // Remapped controller report built from the stored frame bytes.
  typedef struct packed {
    logic [23:0] right_stick_bytes;
    logic [23:0] left_stick_bytes;
    logic [7:0]  buttons_left;
    logic [5:0]  buttons_shared;
    logic [7:0]  buttons_right;
  } report_t;

  // One byte of the CRC, unrolled over its eight bits.
  function automatic byte_t crc8_step(input byte_t crc, input byte_t data);
    byte_t v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  // Hat code to pressed directions.
  function automatic logic [3:0] hat_dirs(input byte_t hat);
    logic [3:0] d;
    case (hat)
      HAT_UP:         d = DIR_UP;
      HAT_UP_RIGHT:   d = DIR_UP | DIR_RIGHT;
      HAT_RIGHT:      d = DIR_RIGHT;
      HAT_DOWN_RIGHT: d = DIR_DOWN | DIR_RIGHT;
      HAT_DOWN:       d = DIR_DOWN;
      HAT_DOWN_LEFT:  d = DIR_DOWN | DIR_LEFT;
      HAT_LEFT:       d = DIR_LEFT;
      HAT_UP_LEFT:    d = DIR_UP | DIR_LEFT;
      default:        d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: src/gfc_remap.sv
`default_nettype none

module gfc_remap (
  input  gfc_pkg::byte_t   frame_bytes [gfc_pkg::STORED_BYTES],
  output gfc_pkg::report_t report
);
  import gfc_pkg::*;

  byte_t      b0;
  byte_t      b1;
  logic [3:0] dirs;

  assign b0   = frame_bytes[0];
  assign b1   = frame_bytes[1];
  assign dirs = hat_dirs(frame_bytes[2]);

  // Face and shoulder buttons; the side buttons are not fitted and read as zero.
  assign report.buttons_right = {b1[7], b1[5], 2'b00, b1[2], b1[1], b1[3], b1[0]};

  // System buttons, with the two stick clicks swapped into place.
  assign report.buttons_shared = {b0[5], b0[4], b0[2], b0[3], b0[1], b0[0]};

  // Hat directions are active low: down, up, right, left from bit 0.
  assign report.buttons_left = {b1[6], b1[4], 2'b00,
                                ~(|(dirs & DIR_LEFT)), ~(|(dirs & DIR_RIGHT)),
                                ~(|(dirs & DIR_UP)),   ~(|(dirs & DIR_DOWN))};

  // Sticks become 12-bit little-endian X followed by an inverted Y byte.
  assign report.left_stick_bytes  = {~frame_bytes[4], 4'h0, frame_bytes[3][7:4],
                                     frame_bytes[3][3:0], 4'h0};
  assign report.right_stick_bytes = {~frame_bytes[6], 4'h0, frame_bytes[5][7:4],
                                     frame_bytes[5][3:0], 4'h0};

endmodule

`default_nettype wire

FILE: src/gamepad_frame_crc_check_remap.sv
`default_nettype none

// Gamepad frame checker. Bytes arrive one per beat on the input stream; a beat
// with in_tuser set opens a nine-byte frame and is its byte 0, abandoning any
// partial frame. Bytes 0 to 7 go through a CRC-8 (polynomial 0x07, initial
// value 0, MSB first) and byte 8 is compared with it. On byte 8 one result beat
// is issued carrying the check flag in out_tuser, both CRC values and the
// remapped report in out_tdata, whether or not the CRC matched. Short frames
// and bytes outside a frame give no result. One byte is taken per clock while
// in_tready is high: the byte-wide CRC update and the remap are combinational
// logic ahead of the result register. Input ready drops only while a result is
// held unread and the next byte would be a CRC byte, so a result is registered
// in the cycle after its CRC byte is taken.
module gamepad_frame_crc_check_remap (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] frame_start

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [7:0] computed_crc, [15:8] received_crc,
                                       // [23:16] buttons_right, [29:24] buttons_shared,
                                       // [37:30] buttons_left, [61:38] left_stick_bytes,
                                       // [85:62] right_stick_bytes, [87:86] zero
  output logic [0:0]       out_tuser   // [0] frame_ok
);
  import gfc_pkg::*;

  logic             frame_active_r, frame_active_nxt;
  logic [POS_W-1:0] byte_pos_r,     byte_pos_nxt;
  byte_t            crc_r,          crc_nxt;
  byte_t            frame_bytes_r [STORED_BYTES];

  logic             out_valid_r, out_valid_nxt;
  logic [87:0]      out_data_r;
  logic             out_ok_r;

  logic             in_beat;
  logic             start;
  logic             at_crc_byte;
  logic             emit;
  logic             store_byte;
  logic [IDX_W-1:0] wr_idx;
  byte_t            crc_in;
  byte_t            crc_step;
  report_t          report;

  // Accept unless a result is waiting and this byte could produce another.
  assign at_crc_byte = frame_active_r && (byte_pos_r == CRC_POS);
  assign in_tready   = !(at_crc_byte && out_valid_r && !out_tready);
  assign in_beat     = in_tvalid && in_tready;
  assign start       = in_tuser[0];
  assign emit        = in_beat && !start && at_crc_byte;

  // Running CRC over the incoming byte; a new frame starts from the seed.
  assign crc_in   = start ? CRC_INIT : crc_r;
  assign crc_step = crc8_step(crc_in, in_tdata);

  // Frame position and CRC tracking.
  always_comb begin
    frame_active_nxt = frame_active_r;
    byte_pos_nxt     = byte_pos_r;
    crc_nxt          = crc_r;
    store_byte       = 1'b0;
    wr_idx           = '0;
    if (in_beat) begin
      if (start) begin
        frame_active_nxt = 1'b1;
        byte_pos_nxt     = POS_W'(1);
        crc_nxt          = crc_step;
        store_byte       = 1'b1;
      end else if (frame_active_r) begin
        if (byte_pos_r < CRC_POS) begin
          crc_nxt      = crc_step;
          byte_pos_nxt = byte_pos_r + POS_W'(1);
          store_byte   = (byte_pos_r < LAST_STORED_POS);
          wr_idx       = byte_pos_r[IDX_W-1:0];
        end else begin
          frame_active_nxt = 1'b0;
          byte_pos_nxt     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_active_r <= 1'b0;
      byte_pos_r     <= '0;
      crc_r          <= CRC_INIT;
    end else begin
      frame_active_r <= frame_active_nxt;
      byte_pos_r     <= byte_pos_nxt;
      crc_r          <= crc_nxt;
    end
  end

  // Report bytes kept for the remap; a new frame writes byte 0 first.
  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame_bytes_r[wr_idx] <= in_tdata;
    end
  end

  gfc_remap u_remap (
    .frame_bytes (frame_bytes_r),
    .report      (report)
  );

  // Result register: loaded on the CRC byte, cleared when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ok_r   <= (crc_r == in_tdata);
      out_data_r <= {2'b00,
                     report.right_stick_bytes,
                     report.left_stick_bytes,
                     report.buttons_left,
                     report.buttons_shared,
                     report.buttons_right,
                     in_tdata,
                     crc_r};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ok_r;

  // The position counter never runs past the CRC byte.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= CRC_POS)
    else $error("byte position beyond the CRC byte");

  // With no open frame the position stays at zero.
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_active_r |-> (byte_pos_r == '0))
    else $error("position not cleared outside a frame");

  // A frame start always leaves an open frame at position one.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && start) |=> (frame_active_r && (byte_pos_r == POS_W'(1))))
    else $error("frame start not taken");

  // A CRC byte always yields a result and closes the frame.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && !frame_active_r))
    else $error("CRC byte gave no result");

  // The check flag agrees with the two CRC fields it was made from.
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ok_r == (out_data_r[7:0] == out_data_r[15:8])))
    else $error("frame_ok disagrees with CRC fields");

endmodule

`default_nettype wire

FILE: dv/gfc_crc_calc_pkg.sv
package gfc_crc_calc_pkg;

  import gfc_pkg::*;

  // Serial form of the frame CRC: one bit at a time, MSB first.
  // The stimulus uses it to close good frames, and the checker uses it for prediction.
  function automatic byte_t crc_byte_update(input byte_t crc, input byte_t data);
    byte_t acc;
    logic  feedback;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

endpackage

FILE: dv/gfc_frame_checker.sv
module gfc_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,  // [7:0] computed_crc, [15:8] received_crc,
                                  // [23:16] buttons_right, [29:24] buttons_shared,
                                  // [37:30] buttons_left, [61:38] left_stick_bytes,
                                  // [85:62] right_stick_bytes, [87:86] zero
  input  logic [0:0]  out_tuser,  // [0] frame_ok
  output int          fail_count,
  output int          reports_outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import gfc_pkg::*;
  import gfc_crc_calc_pkg::*;

  typedef struct packed {
    logic    frame_ok;
    byte_t   computed_crc;
    byte_t   received_crc;
    report_t report;
  } frame_report_t;

  // Shadow copy of the frame receiver.
  logic              frame_open;
  logic [POS_W-1:0]  frame_pos;
  byte_t             crc_acc;
  byte_t             held_bytes [STORED_BYTES];

  frame_report_t     awaited_reports [$];
  frame_report_t     want;
  int                errors = 0;
  int                outstanding = 0;

  assign fail_count          = errors;
  assign reports_outstanding = outstanding;

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] wanted);
    $display("ERROR at %0d ns: %s got 0x%0h, wanted 0x%0h", $time, what, got, wanted);
    errors++;
  endtask

  // Released direction bits of the hat, ordered down, up, right, left from bit 0.
  // A set bit means the direction is not pressed.
  function automatic logic [3:0] hat_released(input byte_t hat);
    logic [3:0] pressed;
    case (hat)
      HAT_UP:         pressed = 4'b0010;
      HAT_UP_RIGHT:   pressed = 4'b0110;
      HAT_RIGHT:      pressed = 4'b0100;
      HAT_DOWN_RIGHT: pressed = 4'b0101;
      HAT_DOWN:       pressed = 4'b0001;
      HAT_DOWN_LEFT:  pressed = 4'b1001;
      HAT_LEFT:       pressed = 4'b1000;
      HAT_UP_LEFT:    pressed = 4'b1010;
      default:        pressed = 4'b0000;
    endcase
    return ~pressed;
  endfunction

  // Stick packed as 12-bit little-endian x followed by the inverted y byte.
  function automatic logic [23:0] stick_pack(input byte_t x, input byte_t y);
    return {~y, 4'h0, x[7:4], x[3:0], 4'h0};
  endfunction

  // Builds the whole result for a frame closed by its CRC byte.
  function automatic frame_report_t remap_frame(input byte_t crc_byte);
    frame_report_t r;
    byte_t b0;
    byte_t b1;
    b0 = held_bytes[0];
    b1 = held_bytes[1];
    r.frame_ok                 = (crc_acc == crc_byte);
    r.computed_crc             = crc_acc;
    r.received_crc             = crc_byte;
    r.report.buttons_right     = {b1[7], b1[5], 2'b00, b1[2], b1[1], b1[3], b1[0]};
    r.report.buttons_shared    = {b0[5], b0[4], b0[2], b0[3], b0[1], b0[0]};
    r.report.buttons_left      = {b1[6], b1[4], 2'b00, hat_released(held_bytes[2])};
    r.report.left_stick_bytes  = stick_pack(held_bytes[3], held_bytes[4]);
    r.report.right_stick_bytes = stick_pack(held_bytes[5], held_bytes[6]);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_open <= 1'b0;
      frame_pos  <= '0;
      crc_acc    <= CRC_INIT;
      awaited_reports.delete();
      outstanding = 0;
    end else begin
      // Result beats are compared first: a result never belongs to a byte taken at the same edge.
      if (out_tvalid && out_tready) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch("result beat with no frame closed", out_tdata[23:0], 24'h0);
        end else begin
          want = awaited_reports.pop_front();
          if (out_tuser[0] !== want.frame_ok)
            report_mismatch("frame_ok", 24'(out_tuser[0]), 24'(want.frame_ok));
          if (out_tdata[7:0] !== want.computed_crc)
            report_mismatch("computed_crc", 24'(out_tdata[7:0]), 24'(want.computed_crc));
          if (out_tdata[15:8] !== want.received_crc)
            report_mismatch("received_crc", 24'(out_tdata[15:8]), 24'(want.received_crc));
          if (out_tdata[23:16] !== want.report.buttons_right)
            report_mismatch("buttons_right", 24'(out_tdata[23:16]),
                            24'(want.report.buttons_right));
          if (out_tdata[29:24] !== want.report.buttons_shared)
            report_mismatch("buttons_shared", 24'(out_tdata[29:24]),
                            24'(want.report.buttons_shared));
          if (out_tdata[37:30] !== want.report.buttons_left)
            report_mismatch("buttons_left", 24'(out_tdata[37:30]),
                            24'(want.report.buttons_left));
          if (out_tdata[61:38] !== want.report.left_stick_bytes)
            report_mismatch("left_stick_bytes", out_tdata[61:38],
                            want.report.left_stick_bytes);
          if (out_tdata[85:62] !== want.report.right_stick_bytes)
            report_mismatch("right_stick_bytes", out_tdata[85:62],
                            want.report.right_stick_bytes);
          if (out_tdata[87:86] !== 2'b00)
            report_mismatch("padding bits", 24'(out_tdata[87:86]), 24'h0);
        end
      end

      // Input beats advance the shadow frame receiver.
      if (in_tvalid && in_tready) begin
        if (in_tuser[0]) begin
          frame_open    <= 1'b1;
          held_bytes[0] <= in_tdata;
          crc_acc       <= crc_byte_update(CRC_INIT, in_tdata);
          frame_pos     <= POS_W'(1);
        end else if (frame_open) begin
          if (frame_pos < CRC_POS) begin
            if (frame_pos < LAST_STORED_POS)
              held_bytes[frame_pos[IDX_W-1:0]] <= in_tdata;
            crc_acc   <= crc_byte_update(crc_acc, in_tdata);
            frame_pos <= frame_pos + POS_W'(1);
          end else begin
            awaited_reports.push_back(remap_frame(in_tdata));
            frame_open <= 1'b0;
            frame_pos  <= '0;
          end
        end
      end
      outstanding = awaited_reports.size();
    end
  end

endmodule

FILE: dv/gamepad_frame_crc_check_remap_test.sv
module gamepad_frame_crc_check_remap_test;

  timeunit 1ns;
  timeprecision 1ps;

  import gfc_pkg::*;
  import gfc_crc_calc_pkg::*;

  localparam int RANDOM_BEATS = 750;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] rx_byte
  logic [0:0]  in_tuser   = 1'b0;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;           // [7:0] computed_crc, [15:8] received_crc,
                                    // [23:16] buttons_right, [29:24] buttons_shared,
                                    // [37:30] buttons_left, [61:38] left_stick_bytes,
                                    // [85:62] right_stick_bytes, [87:86] zero
  logic [0:0]  out_tuser;           // [0] frame_ok

  int fail_count;
  int reports_outstanding;
  int burst_left   = 0;
  int beats_sent   = 0;
  int stall_mode   = 0;
  int stall_left   = 0;
  int stall_phase  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gamepad_frame_crc_check_remap uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  gfc_frame_checker frame_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .fail_count          (fail_count),
    .reports_outstanding (reports_outstanding)
  );

  // The receiver stalls on randomly chosen patterns that change from time to time:
  // always ready, coin toss, mostly stalled, and alternate cycles.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= stall_phase[0];
    endcase
  end

  // Offers one byte and waits for its beat; bursts of beats are broken by random gaps.
  task automatic send_beat(input byte_t data, input bit start, input bit counted);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (counted) beats_sent++;
  endtask

  // Sends eight covered bytes and then a CRC byte that matches or is bent on purpose.
  task automatic send_frame(input byte_t body [8], input bit crc_good);
    byte_t crc;
    byte_t tail;
    crc = CRC_INIT;
    for (int i = 0; i < 8; i++) begin
      crc = crc_byte_update(crc, body[i]);
      send_beat(body[i], i == 0, 1'b1);
    end
    tail = crc_good ? crc : crc ^ byte_t'($urandom_range(1, 255));
    send_beat(tail, 1'b0, 1'b1);
  endtask

  initial begin
    byte_t body [8];
    int    pick;
    int    extra;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Stray bytes before any frame start are dropped.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);

    // All-zero frame with a good CRC: hat pointing up.
    for (int i = 0; i < 8; i++) body[i] = 8'h00;
    send_frame(body, 1'b1);

    // Short frame cut off by the next frame start.
    send_beat(8'h55, 1'b1, 1'b1);
    send_beat(8'hAA, 1'b0, 1'b1);
    send_beat(8'h0F, 1'b0, 1'b1);
    send_beat(8'hF0, 1'b0, 1'b1);

    // All-ones frame with a wrong CRC, hat at centre, then a byte past the end.
    for (int i = 0; i < 8; i++) body[i] = 8'hFF;
    send_frame(body, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b1);

    // Mostly well-formed frames with random content, mixed with broken sequences.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 88 && pick >= 80) begin
        // Short frame; the next frame start abandons it.
        extra = $urandom_range(0, 7);
        send_beat(byte_t'($urandom), 1'b1, 1'b1);
        repeat (extra) send_beat(byte_t'($urandom), 1'b0, 1'b1);
      end else if (pick < 94 && pick >= 88) begin
        // Noise bytes without a frame start.
        extra = $urandom_range(1, 3);
        repeat (extra) send_beat(byte_t'($urandom), 1'b0, 1'b0);
      end else begin
        for (int i = 0; i < 8; i++) body[i] = byte_t'($urandom);
        if ($urandom_range(0, 4) != 0) body[2] = byte_t'($urandom_range(0, 8));
        send_frame(body, $urandom_range(0, 9) < 7);
        // Bytes trailing a complete frame.
        if (pick >= 94) begin
          extra = $urandom_range(1, 3);
          repeat (extra) send_beat(byte_t'($urandom), 1'b0, 1'b0);
        end
      end
    end
    in_tvalid <= 1'b0;

    // Let the checker record the last beat, then drain the results still in flight.
    @(posedge clk);
    while (reports_outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400us;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/gfc_pkg.sv
src/gfc_remap.sv
src/gamepad_frame_crc_check_remap.sv
dv/gfc_crc_calc_pkg.sv
dv/gfc_frame_checker.sv
dv/gamepad_frame_crc_check_remap_test.sv
